// ===== sv/phlm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phlm_pkg
// Shared types, widths and drawing helpers of the peak-hold level meter.
// ----------------------------------------------------------------------------
package phlm_pkg;

    // Field widths
    localparam int MASK_W   = 9;
    localparam int VEL_W    = 7;
    localparam int VEL_FIELDS = 9;
    localparam int LVL_W    = 5;
    localparam int TMR_W    = 7;
    localparam int SCALE_W  = 16;
    localparam int CHAN_W   = 4;
    localparam int COL_W    = 8;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Q4.12 scale: drop 12 fraction bits
    localparam int FRAC_W   = 12;
    localparam int PROD_W   = VEL_W + SCALE_W;

    localparam logic [LVL_W-1:0] MAX_LEVEL = 5'd16;
    localparam logic [LVL_W-1:0] HALF_LEVEL = 5'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_TICKS = 2'd2;

    // Register reset values
    localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RST   = 16'd516;
    localparam logic [TMR_W-1:0]   PEAK_HOLD_TICKS_RST  = 7'd100;
    localparam logic [TMR_W-1:0]   PEAK_DECAY_TICKS_RST = 7'd3;

    // Level/peak pair carried down the result chain
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] peak;
    } res_t;

    // Per-cycle strobes shared by every channel cell
    typedef struct packed {
        logic capture;   // input beat taken into the scale stage
        logic load;      // state update, chain reload
        logic shift;     // chain moves one place toward channel 0
    } ctl_t;

    // Filled bar of h rows (0..8) in one byte, from bit 7 downward
    function automatic logic [COL_W-1:0] bar_byte(input logic [3:0] h);
        logic [15:0] w;
        begin
            w = 16'h00FF << (4'd8 - h);
            return w[7:0];
        end
    endfunction

    // Single dot at height h (0..8); height 0 draws nothing
    function automatic logic [COL_W-1:0] dot_byte(input logic [3:0] h);
        logic [15:0] w;
        begin
            w = 16'h0001 << (4'd8 - h);
            return w[7:0];
        end
    endfunction

endpackage

// ===== sv/phlm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phlm_cell
// One meter channel: velocity scaling stage, level/peak/hold state and one
// place of the result chain that drains toward channel 0.
// ----------------------------------------------------------------------------
module phlm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phlm_pkg::ctl_t                ctl,
    input  logic                          active,
    input  logic [phlm_pkg::VEL_W-1:0]    velocity,
    input  logic [phlm_pkg::SCALE_W-1:0]  velocity_scale,
    input  logic [phlm_pkg::TMR_W-1:0]    peak_hold_ticks,
    input  logic [phlm_pkg::TMR_W-1:0]    peak_decay_ticks,
    input  phlm_pkg::res_t                chain_in,
    output phlm_pkg::res_t                chain_out
);

    logic [phlm_pkg::PROD_W-1:0]          prod;
    logic [phlm_pkg::PROD_W-phlm_pkg::FRAC_W-1:0] shifted;
    logic [phlm_pkg::LVL_W-1:0]           scaled;

    logic [phlm_pkg::LVL_W-1:0] scaled_reg;
    logic                       act_reg;

    logic [phlm_pkg::LVL_W-1:0] level_reg, level_next;
    logic [phlm_pkg::LVL_W-1:0] peak_reg,  peak_next;
    logic [phlm_pkg::TMR_W-1:0] timer_reg, timer_next;

    phlm_pkg::res_t chain_reg;

    // Scale and saturate the velocity
    always_comb
    begin
        prod    = phlm_pkg::PROD_W'(velocity) * phlm_pkg::PROD_W'(velocity_scale);
        shifted = prod[phlm_pkg::PROD_W-1:phlm_pkg::FRAC_W];
        if (shifted > (phlm_pkg::PROD_W-phlm_pkg::FRAC_W)'(phlm_pkg::MAX_LEVEL))
            scaled = phlm_pkg::MAX_LEVEL;
        else
            scaled = shifted[phlm_pkg::LVL_W-1:0];
    end

    // Scale stage register
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            scaled_reg <= scaled;
            act_reg    <= active;
        end
    end

    // Level, peak and hold timer update for one tick
    always_comb
    begin
        level_next = level_reg;
        peak_next  = peak_reg;
        timer_next = timer_reg;
        if (act_reg)
        begin
            level_next = scaled_reg;
            if (scaled_reg > peak_reg)
            begin
                peak_next  = scaled_reg;
                timer_next = peak_hold_ticks;
            end
        end
        else
        begin
            if (level_reg != '0)
                level_next = level_reg - 1'b1;
            if (timer_reg == '0 && peak_reg != '0)
            begin
                peak_next  = peak_reg - 1'b1;
                timer_next = peak_decay_ticks;
            end
            else if (timer_reg != '0)
            begin
                timer_next = timer_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            peak_reg  <= '0;
            timer_reg <= '0;
        end
        else if (ctl.load)
        begin
            level_reg <= level_next;
            peak_reg  <= peak_next;
            timer_reg <= timer_next;
        end
    end

    // Result chain: reload on update, else take the neighbor's entry
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            chain_reg.level <= level_next;
            chain_reg.peak  <= peak_next;
        end
        else if (ctl.shift)
        begin
            chain_reg <= chain_in;
        end
    end

    assign chain_out = chain_reg;

endmodule

// ===== sv/phlm_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phlm_out
// Draws the two column bytes for the channel at the head of the chain and
// holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module phlm_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop,
    input  phlm_pkg::res_t                      head,
    input  logic [phlm_pkg::CHAN_W-1:0]         chan,
    input  logic                                is_last,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [phlm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [phlm_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    logic [phlm_pkg::COL_W-1:0] top;
    logic [phlm_pkg::COL_W-1:0] bot;
    logic [phlm_pkg::LVL_W-1:0] lv_hi;
    logic [phlm_pkg::LVL_W-1:0] pk_hi;

    logic                              vld_reg, vld_next;
    logic [phlm_pkg::OUT_DATA_W-1:0]   data_reg;
    logic [phlm_pkg::OUT_USER_W-1:0]   user_reg;
    logic                              last_reg;

    // Bar with peak dot, split into upper and lower eight rows
    always_comb
    begin
        lv_hi = head.level - phlm_pkg::HALF_LEVEL;
        pk_hi = head.peak - phlm_pkg::HALF_LEVEL;
        if (head.level > phlm_pkg::HALF_LEVEL)
        begin
            top = phlm_pkg::bar_byte(lv_hi[3:0]);
            bot = 8'hFF;
        end
        else
        begin
            top = '0;
            bot = phlm_pkg::bar_byte(head.level[3:0]);
        end
        if (head.peak > phlm_pkg::HALF_LEVEL)
            top = top | phlm_pkg::dot_byte(pk_hi[3:0]);
        else
            bot = bot | phlm_pkg::dot_byte(head.peak[3:0]);
    end

    // Output beat valid
    always_comb
    begin
        vld_next = vld_reg;
        if (pop)
            vld_next = 1'b1;
        else if (m_tready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {6'd0, bot, top, head.peak, head.level};
            user_reg <= chan;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sv/peak_hold_level_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_hold_level_meter
// Per-channel bar meter with peak hold and decay, drawing two column bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one beat per meter tick, carrying the active mask
//   and nine channel velocities. Output channel (m_*): NUM_CHANNELS beats per
//   tick, channels in ascending order, tlast on the final one; tuser holds
//   the channel index.
//   Path: on an idle meter a taken tick passes the scale stage register, the
//   state update and the output register before the first result beat is valid.
//   Throughput: the chain of channel cells drains one result beat per cycle
//   while the receiver is ready; the next tick is taken and scaled while the
//   previous one is still draining.
//   Config port: cfg_we/cfg_addr/cfg_wdata, index 0 velocity_scale (Q4.12),
//   1 peak_hold_ticks, 2 peak_decay_ticks; other indexes are ignored.
//   Write only while the meter is idle.
//   Reset clears all levels, peaks and hold timers and restores registers.
//   A stalled receiver holds the output beat; the chain stops and, once the
//   scale stage is full, s_tready drops.
// ----------------------------------------------------------------------------
module peak_hold_level_meter #(
    parameter int NUM_CHANNELS = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Config write port
    input  logic                                cfg_we,
    input  logic [phlm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [phlm_pkg::SCALE_W-1:0]        cfg_wdata,
    // Tick input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [8:0] active_mask, then velocity_0..velocity_8, 7 bits each from bit 9
    input  logic [phlm_pkg::IN_DATA_W-1:0]      s_tdata,
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [4:0] bar_level, [9:5] peak_level, [17:10] upper_column,
    // [25:18] lower_column, [31:26] zero
    output logic [phlm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [3:0] channel
    output logic [phlm_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    logic [phlm_pkg::SCALE_W-1:0] velocity_scale_reg;
    logic [phlm_pkg::TMR_W-1:0]   peak_hold_ticks_reg;
    logic [phlm_pkg::TMR_W-1:0]   peak_decay_ticks_reg;

    logic             a_vld_reg, a_vld_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic             pop;
    logic             load;
    phlm_pkg::ctl_t   ctl;
    logic [phlm_pkg::CHAN_W-1:0] chan_full;

    phlm_pkg::res_t   chain [NUM_CHANNELS+1];

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_scale_reg   <= phlm_pkg::VELOCITY_SCALE_RST;
            peak_hold_ticks_reg  <= phlm_pkg::PEAK_HOLD_TICKS_RST;
            peak_decay_ticks_reg <= phlm_pkg::PEAK_DECAY_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                phlm_pkg::REG_VELOCITY_SCALE:
                    velocity_scale_reg <= cfg_wdata;
                phlm_pkg::REG_PEAK_HOLD_TICKS:
                    peak_hold_ticks_reg <= cfg_wdata[phlm_pkg::TMR_W-1:0];
                phlm_pkg::REG_PEAK_DECAY_TICKS:
                    peak_decay_ticks_reg <= cfg_wdata[phlm_pkg::TMR_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and chain control
    always_comb
    begin
        pop        = (cnt_reg != '0) && (!m_tvalid || m_tready);
        load       = a_vld_reg && ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pop));
        s_tready   = !a_vld_reg || load;
        accept     = s_tvalid && s_tready;

        a_vld_next = a_vld_reg;
        if (accept)
            a_vld_next = 1'b1;
        else if (load)
            a_vld_next = 1'b0;

        cnt_next = cnt_reg;
        if (load)
            cnt_next = CNT_W'(NUM_CHANNELS);
        else if (pop)
            cnt_next = cnt_reg - 1'b1;

        ctl.capture = accept;
        ctl.load    = load;
        ctl.shift   = pop;

        chan_full = phlm_pkg::CHAN_W'(NUM_CHANNELS) - phlm_pkg::CHAN_W'(cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign chain[NUM_CHANNELS] = '0;

    // Row of channel cells
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_ch
        logic                         ch_active;
        logic [phlm_pkg::VEL_W-1:0]   ch_velocity;

        if (i < phlm_pkg::VEL_FIELDS)
        begin : g_in
            assign ch_active   = s_tdata[i];
            assign ch_velocity =
                s_tdata[phlm_pkg::MASK_W + i*phlm_pkg::VEL_W +: phlm_pkg::VEL_W];
        end
        else
        begin : g_none
            assign ch_active   = 1'b0;
            assign ch_velocity = '0;
        end

        phlm_cell u_ch (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctl              (ctl),
            .active           (ch_active),
            .velocity         (ch_velocity),
            .velocity_scale   (velocity_scale_reg),
            .peak_hold_ticks  (peak_hold_ticks_reg),
            .peak_decay_ticks (peak_decay_ticks_reg),
            .chain_in         (chain[i+1]),
            .chain_out        (chain[i])
        );
    end

    // Drawing and output register
    phlm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .head     (chain[0]),
        .chan     (chan_full),
        .is_last  (cnt_reg == CNT_W'(1)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
